[sv/tlvm_pkg.sv]
// Shared widths, constants and types of the two-line vertex midpoint block.
package tlvm_pkg;

  // Coordinate width, Q15.16 millimetres.
  localparam int CW = 32;
  // Differences and sums of two coordinates.
  localparam int UW = CW + 1;
  // Dot products of two difference vectors, sum of three products.
  localparam int DW = 2 * UW + 1;
  // Determinant and the two numerators.
  localparam int XW = 2 * DW + 1;
  // One product of a determinant term with a coordinate difference.
  localparam int GW = XW + UW;
  // Sum of three such products, plus room for the rounding offset.
  localparam int NW = GW + 2;
  // Divisor 4*D.
  localparam int VW = XW + 1;
  // Quotient magnitude bits.
  localparam int QW = CW;

  localparam int MUL_STAGES = 4;
  localparam int DIV_STAGES = QW + 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // Per-axis vectors of one line pair: u = end1 - start1, v = end2 - start2,
  // w = start1 - start2, s = start1 + start2.
  typedef struct packed {
    logic [2:0][UW-1:0] u;
    logic [2:0][UW-1:0] v;
    logic [2:0][UW-1:0] w;
    logic [2:0][UW-1:0] s;
  } item_t;

endpackage

[sv/tlvm_if.sv]
// Handshake channels for line pairs in and vertices out.
interface tlvm_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] line1_start_x;
  logic signed [31:0] line1_start_y;
  logic signed [31:0] line1_start_z;
  logic signed [31:0] line1_end_x;
  logic signed [31:0] line1_end_y;
  logic signed [31:0] line1_end_z;
  logic signed [31:0] line2_start_x;
  logic signed [31:0] line2_start_y;
  logic signed [31:0] line2_start_z;
  logic signed [31:0] line2_end_x;
  logic signed [31:0] line2_end_y;
  logic signed [31:0] line2_end_z;

  modport source (
    output valid, line1_start_x, line1_start_y, line1_start_z,
    output line1_end_x, line1_end_y, line1_end_z,
    output line2_start_x, line2_start_y, line2_start_z,
    output line2_end_x, line2_end_y, line2_end_z,
    input ready
  );
  modport sink (
    input valid, line1_start_x, line1_start_y, line1_start_z,
    input line1_end_x, line1_end_y, line1_end_z,
    input line2_start_x, line2_start_y, line2_start_z,
    input line2_end_x, line2_end_y, line2_end_z,
    output ready
  );
endinterface

interface tlvm_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic degenerate;

  modport source (output valid, vertex_x, vertex_y, vertex_z, degenerate, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, degenerate, output ready);
endinterface

[sv/two_line_vertex_midpoint.sv]
// Top level of the two-line closest-approach vertex block.
// Throughput: one line pair per cycle while the output side is ready; the multiplier
//   stages and the 33-stage restoring divider are fully pipelined and each accepts a
//   new operand a cycle.
// Reset (rst, synchronous, active high) empties the queue and all stage valids.
module two_line_vertex_midpoint (
  input  logic        clk,
  input  logic        rst,
  tlvm_in_if.sink     points,
  tlvm_out_if.source  vertex
);

  // The input stage converts each pair of lines into its difference vectors
  // u = end1 - start1, v = end2 - start2, w = start1 - start2, plus the sum of
  // the start points, all exact at 33 bits.
  logic            push;
  tlvm_pkg::item_t push_item;
  logic            full;

  tlvm_front u_front (
    .clk, .rst, .points, .push, .push_item, .full
  );

  // A short queue lets the input stage keep taking transactions while the
  // pipeline is held by the output side.
  logic            head_valid;
  tlvm_pkg::item_t head_item;
  logic            pop;

  tlvm_fifo u_fifo (
    .clk, .rst, .push, .push_item, .full, .head_valid, .head_item, .pop
  );

  // The pipeline computes the dot products, the determinant D = ac - b^2 and
  // the two numerators exactly, forms D*(s) + Ns*u + Nt*v for each axis and
  // divides by 2D with rounding to nearest, ties away from zero. Results
  // saturate to the Q15.16 range; D = 0 gives a zero vertex with the
  // degenerate flag set. The whole pipeline advances together and holds
  // when a finished result is not taken.
  tlvm_back u_back (
    .clk, .rst, .head_valid, .head_item, .pop, .vertex
  );

endmodule

[sv/tlvm_front.sv]
// Input stage: accepts a line pair and forms its difference and sum vectors.
module tlvm_front (
  input  logic                clk,
  input  logic                rst,
  tlvm_in_if.sink             points,
  output logic                push,
  output tlvm_pkg::item_t     push_item,
  input  logic                full
);

  logic [2:0][tlvm_pkg::CW-1:0] p1, e1, p2, e2;
  tlvm_pkg::item_t item_next;
  tlvm_pkg::item_t item;
  logic            item_valid;

  always_comb begin
    p1 = {points.line1_start_z, points.line1_start_y, points.line1_start_x};
    e1 = {points.line1_end_z, points.line1_end_y, points.line1_end_x};
    p2 = {points.line2_start_z, points.line2_start_y, points.line2_start_x};
    e2 = {points.line2_end_z, points.line2_end_y, points.line2_end_x};
    for (int k = 0; k < 3; k++) begin
      item_next.u[k] = {e1[k][tlvm_pkg::CW-1], e1[k]} - {p1[k][tlvm_pkg::CW-1], p1[k]};
      item_next.v[k] = {e2[k][tlvm_pkg::CW-1], e2[k]} - {p2[k][tlvm_pkg::CW-1], p2[k]};
      item_next.w[k] = {p1[k][tlvm_pkg::CW-1], p1[k]} - {p2[k][tlvm_pkg::CW-1], p2[k]};
      item_next.s[k] = {p1[k][tlvm_pkg::CW-1], p1[k]} + {p2[k][tlvm_pkg::CW-1], p2[k]};
    end
  end

  assign push         = item_valid && !full;
  assign push_item    = item;
  assign points.ready = !item_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (points.valid && points.ready) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      item <= item_next;
    end
  end

endmodule

[sv/tlvm_fifo.sv]
// Two-entry queue between the input stage and the arithmetic pipeline.
module tlvm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlvm_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output tlvm_pkg::item_t head_item,
  input  logic            pop
);

  tlvm_pkg::item_t                  mem [tlvm_pkg::FIFO_DEPTH];
  logic [tlvm_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [tlvm_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [tlvm_pkg::FIFO_CNT_W-1:0]  count;

  localparam logic [tlvm_pkg::FIFO_CNT_W-1:0] DEPTH_C = tlvm_pkg::FIFO_CNT_W'(tlvm_pkg::FIFO_DEPTH);
  localparam logic [tlvm_pkg::FIFO_PTR_W-1:0] LAST_C =
    tlvm_pkg::FIFO_PTR_W'(tlvm_pkg::FIFO_DEPTH - 1);

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

[sv/tlvm_mul.sv]
// Pipelined signed multiplier: one slice of the second operand per stage.
module tlvm_mul #(
  parameter int WA = 33,
  parameter int WB = 33,
  parameter int NS = 4
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WA-1:0]      a,
  input  logic signed [WB-1:0]      b,
  output logic signed [WA+WB-1:0]   p
);

  localparam int SW  = (WB + NS - 1) / NS;
  localparam int WBX = NS * SW;
  localparam int WP  = WA + WB;

  logic signed [WBX-1:0] bx;
  logic signed [WA-1:0]  a_q   [NS];
  logic signed [WBX-1:0] b_q   [NS];
  logic signed [WP-1:0]  acc_q [NS];

  assign bx = WBX'(b);

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic signed [WA-1:0]  a_in;
    logic signed [WBX-1:0] b_in;
    logic signed [WP-1:0]  acc_in;
    logic signed [SW:0]    dig;
    logic signed [WA+SW:0] pp;

    if (s == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    if (s == NS - 1) begin : g_top
      assign dig = $signed({b_in[s*SW+SW-1], b_in[s*SW +: SW]});
    end else begin : g_low
      assign dig = $signed({1'b0, b_in[s*SW +: SW]});
    end

    assign pp = a_in * dig;

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_in + (WP'(pp) <<< (s * SW));
      end
    end
  end

  assign p = acc_q[NS-1];

endmodule

[sv/tlvm_div.sv]
// Pipelined restoring divider for a 32-bit quotient with overflow detection.
module tlvm_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tlvm_pkg::NW-1:0]  num,
  input  logic [tlvm_pkg::VW-1:0]  den,
  input  logic                     neg,
  output logic [tlvm_pkg::QW-1:0]  mag,
  output logic                     ovf,
  output logic                     neg_out
);

  localparam int NW = tlvm_pkg::NW;
  localparam int VW = tlvm_pkg::VW;
  localparam int QW = tlvm_pkg::QW;

  logic [NW-1:0] r_q   [QW+1];
  logic [VW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];
  logic          neg_q [QW+1];

  // The quotient fits in 32 bits unless num reaches den * 2^32.
  always_ff @(posedge clk) begin
    if (en) begin
      r_q[0]   <= num;
      d_q[0]   <= den;
      q_q[0]   <= '0;
      ovf_q[0] <= (num >= NW'({den, {QW{1'b0}}}));
      neg_q[0] <= neg;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    localparam int J = QW - i;
    logic [NW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_n;

    always_comb begin
      trial  = NW'(d_q[i-1]) << J;
      ge     = (r_q[i-1] >= trial);
      q_n    = q_q[i-1];
      q_n[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[i]   <= ge ? r_q[i-1] - trial : r_q[i-1];
        d_q[i]   <= d_q[i-1];
        q_q[i]   <= q_n;
        ovf_q[i] <= ovf_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
    end
  end

  assign mag     = q_q[QW];
  assign ovf     = ovf_q[QW];
  assign neg_out = neg_q[QW];

endmodule

[sv/tlvm_back.sv]
// Arithmetic pipeline: dot products, determinant, numerators, rounded division.
module tlvm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  tlvm_pkg::item_t head_item,
  output logic            pop,
  tlvm_out_if.source      vertex
);

  localparam int UW = tlvm_pkg::UW;
  localparam int DW = tlvm_pkg::DW;
  localparam int XW = tlvm_pkg::XW;
  localparam int GW = tlvm_pkg::GW;
  localparam int NW = tlvm_pkg::NW;
  localparam int VW = tlvm_pkg::VW;
  localparam int QW = tlvm_pkg::QW;
  localparam int MS = tlvm_pkg::MUL_STAGES;
  localparam int ITEM_DLY = 2 * MS + 2;
  localparam int DEN_DLY  = MS + 1;
  localparam int VLD_LEN  = 3 * MS + 4 + tlvm_pkg::DIV_STAGES;

  logic en;
  logic out_valid;
  logic [VLD_LEN-1:0] vld;

  assign en           = !out_valid || vertex.ready;
  assign pop          = en && head_valid;
  assign vertex.valid = out_valid;

  // Dot products u.u, u.v, v.v, u.w, v.w.
  logic signed [2*UW-1:0] p_uu [3], p_uv [3], p_vv [3], p_uw [3], p_vw [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    tlvm_mul #(.WA(UW), .WB(UW), .NS(MS)) u_uu (.clk, .en,
      .a($signed(head_item.u[k])), .b($signed(head_item.u[k])), .p(p_uu[k]));
    tlvm_mul #(.WA(UW), .WB(UW), .NS(MS)) u_uv (.clk, .en,
      .a($signed(head_item.u[k])), .b($signed(head_item.v[k])), .p(p_uv[k]));
    tlvm_mul #(.WA(UW), .WB(UW), .NS(MS)) u_vv (.clk, .en,
      .a($signed(head_item.v[k])), .b($signed(head_item.v[k])), .p(p_vv[k]));
    tlvm_mul #(.WA(UW), .WB(UW), .NS(MS)) u_uw (.clk, .en,
      .a($signed(head_item.u[k])), .b($signed(head_item.w[k])), .p(p_uw[k]));
    tlvm_mul #(.WA(UW), .WB(UW), .NS(MS)) u_vw (.clk, .en,
      .a($signed(head_item.v[k])), .b($signed(head_item.w[k])), .p(p_vw[k]));
  end

  logic signed [DW-1:0] a_q, b_q, c_q, d_q, e_q;

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= DW'(p_uu[0]) + DW'(p_uu[1]) + DW'(p_uu[2]);
      b_q <= DW'(p_uv[0]) + DW'(p_uv[1]) + DW'(p_uv[2]);
      c_q <= DW'(p_vv[0]) + DW'(p_vv[1]) + DW'(p_vv[2]);
      d_q <= DW'(p_uw[0]) + DW'(p_uw[1]) + DW'(p_uw[2]);
      e_q <= DW'(p_vw[0]) + DW'(p_vw[1]) + DW'(p_vw[2]);
    end
  end

  // D = ac - bb, Ns = be - cd, Nt = ae - bd.
  logic signed [2*DW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_ac (.clk, .en, .a(a_q), .b(c_q), .p(p_ac));
  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_bb (.clk, .en, .a(b_q), .b(b_q), .p(p_bb));
  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_be (.clk, .en, .a(b_q), .b(e_q), .p(p_be));
  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_cd (.clk, .en, .a(c_q), .b(d_q), .p(p_cd));
  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_ae (.clk, .en, .a(a_q), .b(e_q), .p(p_ae));
  tlvm_mul #(.WA(DW), .WB(DW), .NS(MS)) u_bd (.clk, .en, .a(b_q), .b(d_q), .p(p_bd));

  logic signed [XW-1:0] den_q, ns_q, nt_q;

  always_ff @(posedge clk) begin
    if (en) begin
      den_q <= XW'(p_ac) - XW'(p_bb);
      ns_q  <= XW'(p_be) - XW'(p_cd);
      nt_q  <= XW'(p_ae) - XW'(p_bd);
    end
  end

  // The vectors wait here until the determinant terms are ready.
  tlvm_pkg::item_t item_dl [ITEM_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      item_dl[0] <= head_item;
      for (int i = 1; i < ITEM_DLY; i++) begin
        item_dl[i] <= item_dl[i-1];
      end
    end
  end

  // Numerator per axis: D*s + Ns*u + Nt*v.
  logic signed [GW-1:0] p_ds [3], p_nu [3], p_nv [3];
  logic signed [NW-1:0] num_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_num
    tlvm_mul #(.WA(XW), .WB(UW), .NS(MS)) u_ds (.clk, .en,
      .a(den_q), .b($signed(item_dl[ITEM_DLY-1].s[k])), .p(p_ds[k]));
    tlvm_mul #(.WA(XW), .WB(UW), .NS(MS)) u_nu (.clk, .en,
      .a(ns_q), .b($signed(item_dl[ITEM_DLY-1].u[k])), .p(p_nu[k]));
    tlvm_mul #(.WA(XW), .WB(UW), .NS(MS)) u_nv (.clk, .en,
      .a(nt_q), .b($signed(item_dl[ITEM_DLY-1].v[k])), .p(p_nv[k]));

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k] <= NW'(p_ds[k]) + NW'(p_nu[k]) + NW'(p_nv[k]);
      end
    end
  end

  logic signed [XW-1:0] den_dl [DEN_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      den_dl[0] <= den_q;
      for (int i = 1; i < DEN_DLY; i++) begin
        den_dl[i] <= den_dl[i-1];
      end
    end
  end

  // Rounding to nearest: (2|N| + 2D) / 4D.
  logic [NW-1:0] n2_q  [3];
  logic          neg_q [3];
  logic [VW-1:0] div_q;
  logic          deg_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= num_q[k][NW-1];
        n2_q[k]  <= ((num_q[k][NW-1] ? NW'(0) - num_q[k] : num_q[k]) << 1)
                    + (NW'($unsigned(den_dl[DEN_DLY-1])) << 1);
      end
      div_q <= VW'($unsigned(den_dl[DEN_DLY-1])) << 2;
      deg_q <= den_dl[DEN_DLY-1][XW-1] || (den_dl[DEN_DLY-1] == '0);
    end
  end

  logic [QW-1:0] mag [3];
  logic          ovf [3];
  logic          sgn [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    tlvm_div u_div (.clk, .en, .num(n2_q[k]), .den(div_q), .neg(neg_q[k]),
      .mag(mag[k]), .ovf(ovf[k]), .neg_out(sgn[k]));
  end

  logic deg_dl [tlvm_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      deg_dl[0] <= deg_q;
      for (int i = 1; i < tlvm_pkg::DIV_STAGES; i++) begin
        deg_dl[i] <= deg_dl[i-1];
      end
    end
  end

  // Sign, saturation and the degenerate override.
  logic [QW-1:0] res_next [3];
  logic [QW-1:0] res_q    [3];
  logic          deg_out;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      priority if (deg_dl[tlvm_pkg::DIV_STAGES-1]) begin
        res_next[k] = '0;
      end else if (!sgn[k]) begin
        res_next[k] = (ovf[k] || mag[k][QW-1]) ? tlvm_pkg::SAT_MAX : mag[k];
      end else begin
        res_next[k] = (ovf[k] || mag[k] > tlvm_pkg::SAT_MIN) ? tlvm_pkg::SAT_MIN
                                                            : QW'(0) - mag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[VLD_LEN-2:0], pop};
      out_valid <= vld[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        res_q[k] <= res_next[k];
      end
      deg_out <= deg_dl[tlvm_pkg::DIV_STAGES-1];
    end
  end

  assign vertex.vertex_x   = res_q[0];
  assign vertex.vertex_y   = res_q[1];
  assign vertex.vertex_z   = res_q[2];
  assign vertex.degenerate = deg_out;

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && deg_out) |-> (res_q[0] == '0 && res_q[1] == '0 && res_q[2] == '0))
    else $error("degenerate result with nonzero vertex");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_pop_gated: assert property (@(posedge clk) disable iff (rst)
    pop |-> (head_valid && en))
    else $error("queue popped without room in the pipeline");

endmodule

[tb/tb.sv]
// Self-checking testbench for the two-line closest-approach vertex block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for every intermediate term of the vertex formula without overflow.
  localparam int BW = 320;
  localparam int N_RANDOM = 1330;
  // Random idling stops once this many random transactions have been sent.
  localparam int CALM_AFTER = 1150;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [BW-1:0] wide_t;

  // One line pair: start1 xyz, end1 xyz, start2 xyz, end2 xyz.
  typedef struct {
    logic signed [31:0] c[12];
  } pair_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degenerate;
  } vertex_t;

  // A directed row may carry a typed-in result; otherwise it is predicted.
  typedef struct {
    pair_t   pair;
    bit      typed;
    vertex_t vtx;
  } row_t;

  logic clk;
  logic rst;
  tlvm_in_if  points ();
  tlvm_out_if vertex ();

  two_line_vertex_midpoint dut (
    .clk    (clk),
    .rst    (rst),
    .points (points.sink),
    .vertex (vertex.source)
  );

  vertex_t vertex_q[$];
  int      mismatches = 0;
  int      sent = 0;
  bit      calm = 0;
  bit      stim_done = 0;
  int      stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Closest-approach midpoint, computed exactly on wide integers and then rounded
  // to nearest (ties away from zero) and saturated to the coordinate range.
  function automatic vertex_t closest_midpoint(pair_t p);
    wide_t   u[3], v[3], w[3], s[3];
    wide_t   a, b, c, d, e, det, ns, nt, num, mag, q;
    vertex_t r;
    logic signed [31:0] o[3];
    for (int k = 0; k < 3; k++) begin
      u[k] = wide_t'(p.c[3+k]) - wide_t'(p.c[k]);
      v[k] = wide_t'(p.c[9+k]) - wide_t'(p.c[6+k]);
      w[k] = wide_t'(p.c[k]) - wide_t'(p.c[6+k]);
      s[k] = wide_t'(p.c[k]) + wide_t'(p.c[6+k]);
    end
    a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
    b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
    c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
    d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
    e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    det = a*c - b*b;
    if (det <= 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.degenerate = 1'b1;
      return r;
    end
    ns = b*e - c*d;
    nt = a*e - b*d;
    for (int k = 0; k < 3; k++) begin
      num = det*s[k] + ns*u[k] + nt*v[k];
      mag = (num < 0) ? -num : num;
      q = (2*mag + 2*det) / (4*det);
      if (num < 0) q = -q;
      if (q > wide_t'(tlvm_pkg::SAT_MAX)) o[k] = tlvm_pkg::SAT_MAX;
      else if (q < -wide_t'(64'sh80000000)) o[k] = tlvm_pkg::SAT_MIN;
      else o[k] = q[31:0];
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2]; r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic pair_t make_pair(int s1x, int s1y, int s1z, int e1x, int e1y,
                                      int e1z, int s2x, int s2y, int s2z, int e2x,
                                      int e2y, int e2z);
    pair_t p;
    p.c = '{s1x, s1y, s1z, e1x, e1y, e1z, s2x, s2y, s2z, e2x, e2y, e2z};
    return p;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  // Random line pairs of several kinds. Most are well-formed, finite geometry;
  // the rest are full-range noise, parallel lines and collapsed lines.
  function automatic pair_t random_pair();
    pair_t p;
    int    kind;
    int    scale;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) p.c[i] = small_coord();
    case (kind)
      0, 1: begin
        for (int i = 0; i < 12; i++) p.c[i] = $urandom;
      end
      2: begin
        // Second line parallel to the first, scaled by a small integer.
        scale = int'($urandom_range(0, 6)) - 3;
        for (int k = 0; k < 3; k++) begin
          p.c[k] = p.c[k] >>> 2;
          p.c[3+k] = p.c[3+k] >>> 2;
          p.c[6+k] = p.c[6+k] >>> 2;
          p.c[9+k] = p.c[6+k] + scale * (p.c[3+k] - p.c[k]);
        end
      end
      3: begin
        // One of the two lines collapsed to a single point.
        if ($urandom_range(0, 1)) for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k];
        else for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k];
      end
      4: begin
        // Nearly parallel: the second direction differs by one unit in one axis.
        for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k] + (p.c[3+k] - p.c[k]);
        p.c[9 + $urandom_range(0, 2)] += 1;
      end
      5: begin
        // Lines that share their start point, so the vertex is exact.
        for (int k = 0; k < 3; k++) p.c[6+k] = p.c[k];
      end
      default: ;
    endcase
    return p;
  endfunction

  // Drives one line pair and waits for its transaction; the expectation is
  // queued at the edge where the transaction completes.
  task automatic send_pair(pair_t p, bit typed, vertex_t vtx);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid <= 1'b1;
    points.line1_start_x <= p.c[0];
    points.line1_start_y <= p.c[1];
    points.line1_start_z <= p.c[2];
    points.line1_end_x   <= p.c[3];
    points.line1_end_y   <= p.c[4];
    points.line1_end_z   <= p.c[5];
    points.line2_start_x <= p.c[6];
    points.line2_start_y <= p.c[7];
    points.line2_start_z <= p.c[8];
    points.line2_end_x   <= p.c[9];
    points.line2_end_y   <= p.c[10];
    points.line2_end_z   <= p.c[11];
    do @(posedge clk); while (!points.ready);
    vertex_q.push_back(typed ? vtx : closest_midpoint(p));
    sent++;
  endtask

  // The receiver stalls in random bursts until the run turns calm.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst || calm) begin
      vertex.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      vertex.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      vertex.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      vertex.ready <= 1'b1;
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && vertex.valid && vertex.ready) begin
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected vertex %h %h %h deg=%b", vertex.vertex_x,
                   vertex.vertex_y, vertex.vertex_z, vertex.degenerate);
      end else begin
        want = vertex_q.pop_front();
        if (vertex.vertex_x !== want.x || vertex.vertex_y !== want.y ||
            vertex.vertex_z !== want.z || vertex.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: vertex exp %h %h %h deg=%b got %h %h %h deg=%b",
                     want.x, want.y, want.z, want.degenerate, vertex.vertex_x,
                     vertex.vertex_y, vertex.vertex_z, vertex.degenerate);
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((points.valid && points.ready) || (vertex.valid && vertex.ready) || rst)
      stall_cycles <= 0;
    else if (!stim_done || vertex_q.size() != 0)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t    rows[$];
    row_t    r;
    vertex_t none;
    localparam int ONE = 32'sh0001_0000;
    localparam int MAXC = 32'sh7FFF_FFFF;
    localparam int MINC = 32'sh8000_0000;

    rst = 1'b1;
    points.valid <= 1'b0;
    points.line1_start_x <= '0; points.line1_start_y <= '0; points.line1_start_z <= '0;
    points.line1_end_x <= '0; points.line1_end_y <= '0; points.line1_end_z <= '0;
    points.line2_start_x <= '0; points.line2_start_y <= '0; points.line2_start_z <= '0;
    points.line2_end_x <= '0; points.line2_end_y <= '0; points.line2_end_z <= '0;
    none = '{x: '0, y: '0, z: '0, degenerate: 1'b0};

    // Directed rows. Degenerate cases and simple crossings are typed in; the
    // extreme coordinates are left to the predictor.
    r.typed = 1'b1;
    r.pair = make_pair(0,0,0, 0,0,0, 0,0,0, 0,0,0);
    r.vtx = '{x: '0, y: '0, z: '0, degenerate: 1'b1};
    rows.push_back(r);
    // Two identical lines are parallel.
    r.pair = make_pair(ONE,2*ONE,3*ONE, 4*ONE,5*ONE,6*ONE,
                       ONE,2*ONE,3*ONE, 4*ONE,5*ONE,6*ONE);
    rows.push_back(r);
    // A line and its reverse across the far corners of the range are parallel.
    r.pair = make_pair(MINC,MINC,MINC, MAXC,MAXC,MAXC, MAXC,MAXC,MAXC, MINC,MINC,MINC);
    rows.push_back(r);
    // Line 1 along x at z = 0, line 2 along y through x = 3, z = 2: vertex (3, 0, 1).
    r.pair = make_pair(0,0,0, ONE,0,0, 3*ONE,-ONE,2*ONE, 3*ONE,ONE,2*ONE);
    r.vtx = '{x: 3*ONE, y: 0, z: ONE, degenerate: 1'b0};
    rows.push_back(r);
    // Lines that cross at (-5, 7, -1).
    r.pair = make_pair(-6*ONE,7*ONE,-ONE, -4*ONE,7*ONE,-ONE,
                       -5*ONE,7*ONE,0, -5*ONE,7*ONE,-2*ONE);
    r.vtx = '{x: -5*ONE, y: 7*ONE, z: -ONE, degenerate: 1'b0};
    rows.push_back(r);
    // A half-lsb midpoint is a tie and rounds away from zero: z midway between 0 and 1 lsb.
    r.pair = make_pair(0,0,0, ONE,0,0, 0,0,1, 0,ONE,1);
    r.vtx = '{x: 0, y: 0, z: 1, degenerate: 1'b0};
    rows.push_back(r);
    r.pair = make_pair(0,0,0, ONE,0,0, 0,0,-1, 0,ONE,-1);
    r.vtx = '{x: 0, y: 0, z: -1, degenerate: 1'b0};
    rows.push_back(r);

    r.typed = 1'b0;
    r.vtx = none;
    // Extreme coordinates, full-range directions and all-ones patterns.
    rows.push_back('{make_pair(MAXC,MAXC,MAXC, MINC,MINC,MINC,
                               MINC,MAXC,0, MAXC,MINC,-1), 1'b0, none});
    rows.push_back('{make_pair(MINC,0,MAXC, MAXC,-1,MINC,
                               0,MINC,MAXC, -1,MAXC,MINC), 1'b0, none});
    rows.push_back('{make_pair(-1,-1,-1, MAXC,0,0, 0,MAXC,0, 0,0,MAXC), 1'b0, none});
    rows.push_back('{make_pair(MAXC,MAXC,0, MAXC,MAXC,1, MINC,MINC,0, MINC,MINC,-1),
                     1'b0, none});
    // Nearly parallel lines far apart; the last of these drives the vertex to saturation.
    rows.push_back('{make_pair(0,0,0, MAXC,0,0, 0,MAXC,0, MAXC,MAXC,1), 1'b0, none});
    rows.push_back('{make_pair(0,0,0, MAXC,0,0, 0,MINC,0, MAXC,MINC,-1), 1'b0, none});
    rows.push_back('{make_pair(MINC,MINC,MINC, MAXC,MINC,MINC,
                               MAXC,MAXC,MAXC, MINC,MAXC,MAXC-1), 1'b0, none});
    // Skew lines with fractional parts.
    rows.push_back('{make_pair(12345,-678,9, 99999,4321,-77,
                               -5555,31337,2024, 7,-8,65537), 1'b0, none});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].vtx);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == CALM_AFTER) calm = 1'b1;
      send_pair(random_pair(), 1'b0, none);
    end
    points.valid <= 1'b0;
    stim_done = 1'b1;

    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
